>>> rtl/core/look_at_view_matrix_assert.svh
// assertion macros for the look-at view matrix checker
// no dependencies; included by files that hold concurrent checks
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// check sampled on clk, masked while reset is asserted
`define LAV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define LAV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lav_pkg.sv
// shared widths, constants and types for the look-at view matrix pipeline
// no dependencies; imported by the normalizer, dot unit and top level
`default_nettype none

package lav_pkg;

    localparam int VW     = 18;           // unit vector component, signed q2.16
    localparam int CW     = 32;           // coordinate width, signed q16.16
    localparam int FRAC   = 16;           // fraction bits
    localparam int MW     = 30;           // magnitude width after normalizing shift
    localparam int SQW    = 2 * MW + 2;   // sum of three squares
    localparam int RW     = SQW / 2;      // integer square root width
    localparam int RMW    = RW + 3;       // square root remainder width
    localparam int QW     = FRAC + 1;     // quotient bits of a unit component
    localparam int DRW    = RW + 1;       // divider remainder width
    localparam int PW     = CW + VW;      // eye times unit component
    localparam int SUMW   = PW + 2;       // sum of three such products
    localparam int IN_TW  = 9 * CW;       // input tdata width
    localparam int OUT_TW = 264;          // output tdata width, byte padded

    localparam logic signed [VW-1:0] FX_ONE = 18'sd65536;

    typedef logic signed [VW-1:0] unit_t;
    typedef logic signed [CW-1:0] coord_t;

endpackage

`default_nettype wire

>>> rtl/core/lav_norm.sv
// pipelined 3-vector normalizer: magnitude, two-step normalizing shift,
// squares, bit-per-stage square root and bit-per-stage division; uses lav_pkg
`default_nettype none

module lav_norm
    import lav_pkg::*;
#(
    parameter int W  = 33,
    parameter int SW = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] in_vec [3],
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_valid,
    output unit_t                    out_vec [3],
    output logic [SW-1:0]            out_side
);

    localparam int NG   = (W + 7) / 8;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW = NG * 8;
    localparam int BW   = MW + 8;
    localparam int EW   = PADW + BW;
    localparam int CRW  = 3 * MW + 4 + SW;
    localparam int DCW  = SW + 4;
    localparam int NUMW = MW + FRAC + 1;

    // stage a: magnitudes and maximum
    logic           va_reg;
    logic [2:0]     nega_reg, nega_next;
    logic [W-1:0]   maga_reg [3];
    logic [W-1:0]   maga_next [3];
    logic [W-1:0]   mxa_reg, mxa_next;
    logic [SW-1:0]  sda_reg;

    always_comb
    begin
        logic [W-1:0] u;
        for (int i = 0; i < 3; i++)
        begin
            u            = in_vec[i];
            nega_next[i] = u[W-1];
            maga_next[i] = u[W-1] ? (~u + 1'b1) : u;
        end
        mxa_next = maga_next[0];
        if (maga_next[1] > mxa_next)
        begin
            mxa_next = maga_next[1];
        end
        if (maga_next[2] > mxa_next)
        begin
            mxa_next = maga_next[2];
        end
    end

    // stage b: coarse shift by whole bytes
    logic           vb_reg;
    logic [2:0]     negb_reg;
    logic [BW-1:0]  winb_reg [3];
    logic [BW-1:0]  winb_next [3];
    logic [7:0]     byteb_reg, byteb_next;
    logic           zb_reg, zb_next;
    logic [SW-1:0]  sdb_reg;

    always_comb
    begin
        logic [PADW-1:0] mxp;
        logic [GW-1:0]   gsel;
        logic [EW-1:0]   e;
        mxp  = PADW'(mxa_reg);
        gsel = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (|mxp[g*8 +: 8])
            begin
                gsel = GW'(g);
            end
        end
        byteb_next = mxp[{gsel, 3'b000} +: 8];
        zb_next    = (mxa_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            e            = EW'(maga_reg[i]) << MW;
            winb_next[i] = BW'(e >> {gsel, 3'b000});
        end
    end

    // stage c: fine shift, leading one of the maximum lands on bit MW-1
    logic           vc_reg;
    logic [2:0]     negc_reg;
    logic [MW-1:0]  mc_reg [3];
    logic [MW-1:0]  mc_next [3];
    logic           zc_reg;
    logic [SW-1:0]  sdc_reg;

    always_comb
    begin
        logic [2:0] j;
        j = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (byteb_reg[b])
            begin
                j = 3'(b);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            mc_next[i] = MW'(winb_reg[i] >> ({1'b0, j} + 4'd1));
        end
    end

    // stage d: squares
    logic            vd_reg;
    logic [2:0]      negd_reg;
    logic [MW-1:0]   md_reg [3];
    logic [2*MW-1:0] sqd_reg [3];
    logic [2*MW-1:0] sqd_next [3];
    logic            zd_reg;
    logic [SW-1:0]   sdd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqd_next[i] = mc_reg[i] * mc_reg[i];
        end
    end

    // stage e feeds the square root chain at index 0
    logic [SQW-1:0] sum_next;
    assign sum_next = SQW'(sqd_reg[0]) + SQW'(sqd_reg[1]) + SQW'(sqd_reg[2]);

    logic           rv_reg [RW+1];
    logic [SQW-1:0] rx_reg [RW+1];
    logic [RMW-1:0] rr_reg [RW+1];
    logic [RW-1:0]  rq_reg [RW+1];
    logic [CRW-1:0] rc_reg [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vd_reg    <= 1'b0;
            rv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= in_valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg    <= vc_reg;
            rv_reg[0] <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nega_reg  <= nega_next;
            maga_reg  <= maga_next;
            mxa_reg   <= mxa_next;
            sda_reg   <= in_side;
            negb_reg  <= nega_reg;
            winb_reg  <= winb_next;
            byteb_reg <= byteb_next;
            zb_reg    <= zb_next;
            sdb_reg   <= sda_reg;
            negc_reg  <= negb_reg;
            mc_reg    <= mc_next;
            zc_reg    <= zb_reg;
            sdc_reg   <= sdb_reg;
            negd_reg  <= negc_reg;
            md_reg    <= mc_reg;
            sqd_reg   <= sqd_next;
            zd_reg    <= zc_reg;
            sdd_reg   <= sdc_reg;
            rx_reg[0] <= sum_next;
            rr_reg[0] <= '0;
            rq_reg[0] <= '0;
            rc_reg[0] <= {sdd_reg, zd_reg, negd_reg, md_reg[2], md_reg[1], md_reg[0]};
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_root
        logic [RMW-1:0] rem_t, trial, rr_next;
        logic [RW-1:0]  rq_next;

        always_comb
        begin
            rem_t = {rr_reg[k][RMW-3:0], rx_reg[k][SQW-1 -: 2]};
            trial = RMW'({rq_reg[k], 2'b01});
            if (rem_t >= trial)
            begin
                rr_next = rem_t - trial;
                rq_next = {rq_reg[k][RW-2:0], 1'b1};
            end
            else
            begin
                rr_next = rem_t;
                rq_next = {rq_reg[k][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                rv_reg[k+1] <= rv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1] <= rx_reg[k] << 2;
                rr_reg[k+1] <= rr_next;
                rq_reg[k+1] <= rq_next;
                rc_reg[k+1] <= rc_reg[k];
            end
        end
    end

    // division setup: rounded numerator, high part already below the length
    logic           dv_reg   [QW+1];
    logic [RW-1:0]  dlen_reg [QW+1];
    logic [DRW-1:0] drem_reg [QW+1][3];
    logic [QW-1:0]  dlow_reg [QW+1][3];
    logic [QW-1:0]  dq_reg   [QW+1][3];
    logic [DCW-1:0] dc_reg   [QW+1];

    logic [DRW-1:0] drem0_next [3];
    logic [QW-1:0]  dlow0_next [3];

    always_comb
    begin
        logic [MW-1:0]   mi;
        logic [NUMW-1:0] num;
        for (int i = 0; i < 3; i++)
        begin
            mi            = rc_reg[RW][MW*i +: MW];
            num           = NUMW'({mi, {FRAC{1'b0}}}) + NUMW'(rq_reg[RW] >> 1);
            drem0_next[i] = DRW'(num >> QW);
            dlow0_next[i] = num[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= rv_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlen_reg[0] <= rq_reg[RW];
            drem_reg[0] <= drem0_next;
            dlow_reg[0] <= dlow0_next;
            dq_reg[0]   <= '{default: '0};
            dc_reg[0]   <= rc_reg[RW][CRW-1:3*MW];
        end
    end

    // restoring division, one quotient bit per stage on all three lanes
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DRW-1:0] drem_next [3];
        logic [QW-1:0]  dlow_next [3];
        logic [QW-1:0]  dq_next   [3];

        always_comb
        begin
            logic [DRW-1:0] rt;
            for (int i = 0; i < 3; i++)
            begin
                rt           = {drem_reg[k][i][DRW-2:0], dlow_reg[k][i][QW-1]};
                dlow_next[i] = dlow_reg[k][i] << 1;
                if (rt >= DRW'(dlen_reg[k]))
                begin
                    drem_next[i] = rt - DRW'(dlen_reg[k]);
                    dq_next[i]   = {dq_reg[k][i][QW-2:0], 1'b1};
                end
                else
                begin
                    drem_next[i] = rt;
                    dq_next[i]   = {dq_reg[k][i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dlen_reg[k+1] <= dlen_reg[k];
                drem_reg[k+1] <= drem_next;
                dlow_reg[k+1] <= dlow_next;
                dq_reg[k+1]   <= dq_next;
                dc_reg[k+1]   <= dc_reg[k];
            end
        end
    end

    // sign and zero-vector fixup
    logic          ov_reg;
    unit_t         ovec_reg [3];
    unit_t         ovec_next [3];
    logic [SW-1:0] oside_reg;

    always_comb
    begin
        unit_t mag;
        for (int i = 0; i < 3; i++)
        begin
            mag = unit_t'({1'b0, dq_reg[QW][i]});
            if (dc_reg[QW][3])
            begin
                ovec_next[i] = (i == 0) ? FX_ONE : '0;
            end
            else if (dc_reg[QW][i])
            begin
                ovec_next[i] = -mag;
            end
            else
            begin
                ovec_next[i] = mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovec_reg  <= ovec_next;
            oside_reg <= dc_reg[QW][DCW-1:4];
        end
    end

    assign out_valid = ov_reg;
    assign out_vec   = ovec_reg;
    assign out_side  = oside_reg;

endmodule

`default_nettype wire

>>> rtl/core/lav_cross.sv
// two-stage cross product: registered partial products, then differences
// no package dependency
`default_nettype none

module lav_cross #(
    parameter int AW = 18,
    parameter int BW = 32,
    parameter int SW = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [AW-1:0]    a [3],
    input  wire logic signed [BW-1:0]    b [3],
    input  wire logic [SW-1:0]           in_side,
    output logic                         out_valid,
    output logic signed [AW+BW:0]        r [3],
    output logic [SW-1:0]                out_side
);

    localparam int PW2 = AW + BW;
    localparam int OW  = PW2 + 1;

    logic                  v1_reg, v2_reg;
    logic signed [PW2-1:0] p_reg [6];
    logic signed [PW2-1:0] p_next [6];
    logic [SW-1:0]         s1_reg, s2_reg;
    logic signed [OW-1:0]  r_reg [3];
    logic signed [OW-1:0]  r_next [3];

    always_comb
    begin
        p_next[0] = a[1] * b[2];
        p_next[1] = a[2] * b[1];
        p_next[2] = a[2] * b[0];
        p_next[3] = a[0] * b[2];
        p_next[4] = a[0] * b[1];
        p_next[5] = a[1] * b[0];
        for (int i = 0; i < 3; i++)
        begin
            r_next[i] = OW'(p_reg[2*i]) - OW'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p_next;
            s1_reg <= in_side;
            r_reg  <= r_next;
            s2_reg <= s1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign r         = r_reg;
    assign out_side  = s2_reg;

endmodule

`default_nettype wire

>>> rtl/core/lav_dot.sv
// three dot products of the eye with the basis rows, rounded and saturated
// to q16.16; three register stages; uses lav_pkg
`default_nettype none

module lav_dot
    import lav_pkg::*;
#(
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire coord_t        eye [3],
    input  wire unit_t         rs [3],
    input  wire unit_t         ru [3],
    input  wire unit_t         rf [3],
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output coord_t             shift [3],
    output logic [SW-1:0]      out_side
);

    localparam int RDW = SUMW - FRAC;
    localparam logic [RDW-1:0] POS_MAX = {{(RDW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [RDW-1:0] NEG_MAX = POS_MAX + 1'b1;
    localparam logic [SUMW-1:0] HALF   = SUMW'(1) << (FRAC - 1);

    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [PW-1:0]   p_reg [9];
    logic signed [PW-1:0]   p_next [9];
    logic signed [SUMW-1:0] s_reg [3];
    logic signed [SUMW-1:0] s_next [3];
    coord_t                 t_reg [3];
    coord_t                 t_next [3];
    logic [SW-1:0]          d1_reg, d2_reg, d3_reg;

    always_comb
    begin
        logic signed [SUMW-1:0] acc;
        logic [SUMW-1:0]        mag;
        logic [RDW-1:0]         rd;
        for (int i = 0; i < 3; i++)
        begin
            p_next[i]     = eye[i] * rs[i];
            p_next[3 + i] = eye[i] * ru[i];
            p_next[6 + i] = eye[i] * rf[i];
        end
        for (int j = 0; j < 3; j++)
        begin
            acc = SUMW'(p_reg[3*j]) + SUMW'(p_reg[3*j+1]) + SUMW'(p_reg[3*j+2]);
            // right and up rows are negated, forward is not
            s_next[j] = (j == 2) ? acc : -acc;
        end
        for (int j = 0; j < 3; j++)
        begin
            mag = s_reg[j][SUMW-1] ? (~s_reg[j] + 1'b1) : s_reg[j];
            rd  = RDW'((mag + HALF) >> FRAC);
            if (s_reg[j][SUMW-1])
            begin
                t_next[j] = (rd > NEG_MAX) ? coord_t'(NEG_MAX) : CW'(~rd + 1'b1);
            end
            else
            begin
                t_next[j] = (rd > POS_MAX) ? coord_t'(POS_MAX) : CW'(rd);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p_next;
            s_reg  <= s_next;
            t_reg  <= t_next;
            d1_reg <= in_side;
            d2_reg <= d1_reg;
            d3_reg <= d2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign shift     = t_reg;
    assign out_side  = d3_reg;

endmodule

`default_nettype wire

>>> rtl/core/look_at_view_matrix.sv
// depth: 173 register stages from the input register to the last dot stage,
//   which is the output register
// throughput: one transaction per cycle; the whole pipeline advances while the
//   output register is empty or being taken, and holds as one otherwise
// the depth is set by the three normalizers: 31 square-root and 17 divider stages each
// reset: asynchronous active low, clears all valid bits; data registers are not reset
// depends on lav_pkg, lav_norm, lav_cross and lav_dot
`default_nettype none

module look_at_view_matrix
    import lav_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, hint_up_x, hint_up_y, hint_up_z
    input  wire logic [IN_TW-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // side_x/y/z, true_up_x/y/z, back_x/y/z (18 bits each), shift_x/y/z (32 bits
    // each), 6 zero pad bits
    output logic [OUT_TW-1:0]      m_axis_tdata
);

    localparam int DW  = CW + 1;          // aim minus eye
    localparam int X1W = VW + CW + 1;     // forward cross hint up
    localparam int X2W = 2 * VW + 1;      // right cross forward
    localparam int S1W = 6 * CW;
    localparam int S2W = 3 * VW + 3 * CW;
    localparam int S3W = 6 * VW + 3 * CW;
    localparam int RTW = 9 * VW;

    // global advance: every stage moves when the output slot frees up
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input register: unpack and form aim minus eye
    logic              v0_reg;
    coord_t            eye0_reg [3];
    coord_t            up0_reg  [3];
    logic signed [DW-1:0] diff0_reg  [3];
    logic signed [DW-1:0] diff0_next [3];
    coord_t            eye_in [3];
    coord_t            aim_in [3];
    coord_t            up_in  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_in[i]     = s_axis_tdata[CW*i +: CW];
            aim_in[i]     = s_axis_tdata[CW*(3+i) +: CW];
            up_in[i]      = s_axis_tdata[CW*(6+i) +: CW];
            diff0_next[i] = DW'(aim_in[i]) - DW'(eye_in[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eye0_reg  <= eye_in;
            up0_reg   <= up_in;
            diff0_reg <= diff0_next;
        end
    end

    // forward = normalize(aim - eye); eye and hint up ride along
    logic           n1_valid;
    unit_t          fwd1 [3];
    logic [S1W-1:0] n1_side;
    coord_t         eye1 [3];
    coord_t         up1  [3];

    lav_norm #(
        .W  (DW),
        .SW (S1W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_vec    (diff0_reg),
        .in_side   ({up0_reg[2], up0_reg[1], up0_reg[0],
                     eye0_reg[2], eye0_reg[1], eye0_reg[0]}),
        .out_valid (n1_valid),
        .out_vec   (fwd1),
        .out_side  (n1_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye1[i] = n1_side[CW*i +: CW];
            up1[i]  = n1_side[CW*(3+i) +: CW];
        end
    end

    // unnormalized right = forward x hint up
    logic                  x1_valid;
    logic signed [X1W-1:0] x1_vec [3];
    logic [S2W-1:0]        x1_side;

    lav_cross #(
        .AW (VW),
        .BW (CW),
        .SW (S2W)
    ) u_cross_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n1_valid),
        .a         (fwd1),
        .b         (up1),
        .in_side   ({fwd1[2], fwd1[1], fwd1[0], eye1[2], eye1[1], eye1[0]}),
        .out_valid (x1_valid),
        .r         (x1_vec),
        .out_side  (x1_side)
    );

    // right = normalize(forward x hint up)
    logic           n2_valid;
    unit_t          side2 [3];
    logic [S2W-1:0] n2_side;
    coord_t         eye2 [3];
    unit_t          fwd2 [3];

    lav_norm #(
        .W  (X1W),
        .SW (S2W)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x1_valid),
        .in_vec    (x1_vec),
        .in_side   (x1_side),
        .out_valid (n2_valid),
        .out_vec   (side2),
        .out_side  (n2_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye2[i] = n2_side[CW*i +: CW];
            fwd2[i] = n2_side[3*CW + VW*i +: VW];
        end
    end

    // unnormalized true up = right x forward
    logic                  x2_valid;
    logic signed [X2W-1:0] x2_vec [3];
    logic [S3W-1:0]        x2_side;

    lav_cross #(
        .AW (VW),
        .BW (VW),
        .SW (S3W)
    ) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .a         (side2),
        .b         (fwd2),
        .in_side   ({side2[2], side2[1], side2[0], fwd2[2], fwd2[1], fwd2[0],
                     eye2[2], eye2[1], eye2[0]}),
        .out_valid (x2_valid),
        .r         (x2_vec),
        .out_side  (x2_side)
    );

    // true up = normalize(right x forward)
    logic           n3_valid;
    unit_t          tup3 [3];
    logic [S3W-1:0] n3_side;
    coord_t         eye3  [3];
    unit_t          fwd3  [3];
    unit_t          side3 [3];
    unit_t          back3 [3];

    lav_norm #(
        .W  (X2W),
        .SW (S3W)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x2_valid),
        .in_vec    (x2_vec),
        .in_side   (x2_side),
        .out_valid (n3_valid),
        .out_vec   (tup3),
        .out_side  (n3_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye3[i]  = n3_side[CW*i +: CW];
            fwd3[i]  = n3_side[3*CW + VW*i +: VW];
            side3[i] = n3_side[3*CW + 3*VW + VW*i +: VW];
            // forward lies in [-1, 1], so its negation fits
            back3[i] = -fwd3[i];
        end
    end

    // translations; the rotation rows ride along to the output register
    logic           d_valid;
    coord_t         shift_q [3];
    logic [RTW-1:0] rot_q;

    lav_dot #(
        .SW (RTW)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n3_valid),
        .eye       (eye3),
        .rs        (side3),
        .ru        (tup3),
        .rf        (fwd3),
        .in_side   ({back3[2], back3[1], back3[0], tup3[2], tup3[1], tup3[0],
                     side3[2], side3[1], side3[0]}),
        .out_valid (d_valid),
        .shift     (shift_q),
        .out_side  (rot_q)
    );

    // the last dot stage is the output register
    assign m_axis_tvalid = d_valid;
    assign m_axis_tdata  = {{(OUT_TW-RTW-3*CW){1'b0}},
                            shift_q[2], shift_q[1], shift_q[0], rot_q};

endmodule

`default_nettype wire

>>> rtl/core/lav_check.sv
// port-level checks for the look-at view matrix, bound to the top level
// depends on look_at_view_matrix_assert.svh
`default_nettype none

`include "look_at_view_matrix_assert.svh"

module lav_check (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [263:0] m_axis_tdata
);

    // a waiting result keeps its transaction
    `LAV_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // the input side stalls only when the output register is full and not taken
    `LAV_ASSERT(a_in_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output slot")

    // pad bits of a result are zero
    `LAV_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[263:258] == 6'd0, "pad bits set")

    // nothing is offered while in reset
    `LAV_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);

`default_nettype wire

>>> verif/look_at_view_matrix_tb.sv
// self-checking testbench for the look-at view matrix pipeline
// depends on lav_pkg and look_at_view_matrix; predicts each result bit for bit
`default_nettype none

module look_at_view_matrix_tb;
    import lav_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint signed vec3_t [3];
    typedef logic [IN_TW-1:0]  view_in_t;
    typedef logic [OUT_TW-1:0] view_out_t;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 400;     // idle wait after the last owed result has been taken
    localparam int RANDOM_ITEMS = 1830;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_TW-1:0] m_axis_tdata;

    look_at_view_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // pending stimulus and the matrices still owed by the block
    view_in_t  camera_q [$];
    bit        hold_q   [$];       // sender waits for an empty pipeline before this one
    view_out_t matrix_q [$];

    int errors;
    int sent;
    int taken;
    int degenerate_cnt;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // unit vector: magnitudes scaled together into [2^29, 2^30), rounded divide
    function automatic vec3_t unit_vec(vec3_t v);
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned peak;
        longint unsigned len;
        longint unsigned q;
        vec3_t           r;
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            // zero length falls back to the x axis
            r[0] = 65536;
            r[1] = 0;
            r[2] = 0;
            return r;
        end
        while (peak >= (64'd1 << 30))
        begin
            peak = peak >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        while (peak < (64'd1 << 29))
        begin
            peak = peak << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 16) + len / 2) / len;
            r[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    function automatic vec3_t cross_of(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // q32.32 dot product rounded half away from zero to q16.16, saturated
    function automatic logic [31:0] shift_term(vec3_t a, vec3_t b, bit negate);
        longint signed   acc;
        longint unsigned m;
        longint signed   q;
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        if (negate)
            acc = -acc;
        m = (acc < 0) ? -acc : acc;
        m = (m + 32768) >> 16;
        q = (acc < 0) ? -longint'(m) : longint'(m);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic view_out_t view_matrix(view_in_t cam);
        vec3_t     eye;
        vec3_t     diff;
        vec3_t     hint;
        vec3_t     fwd;
        vec3_t     side;
        vec3_t     tup;
        vec3_t     neg_fwd;
        view_out_t res;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = longint'($signed(cam[32*i +: 32]));
            diff[i] = longint'($signed(cam[32*(3+i) +: 32])) - eye[i];
            hint[i] = longint'($signed(cam[32*(6+i) +: 32]));
        end
        fwd  = unit_vec(diff);
        side = unit_vec(cross_of(fwd, hint));
        tup  = unit_vec(cross_of(side, fwd));
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg_fwd[i] = -fwd[i];
            res[18*i +: 18]     = side[i][17:0];
            res[18*(3+i) +: 18] = tup[i][17:0];
            res[18*(6+i) +: 18] = neg_fwd[i][17:0];
        end
        res[162 +: 32] = shift_term(eye, side, 1'b1);
        res[194 +: 32] = shift_term(eye, tup, 1'b1);
        res[226 +: 32] = shift_term(eye, fwd, 1'b0);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic view_in_t pack_cam(vec3_t e, vec3_t a, vec3_t u);
        view_in_t d;
        for (int i = 0; i < 3; i++)
        begin
            d[32*i +: 32]     = e[i][31:0];
            d[32*(3+i) +: 32] = a[i][31:0];
            d[32*(6+i) +: 32] = u[i][31:0];
        end
        return d;
    endfunction

    // mostly short gaps, a few long ones, and occasional gap-free stretches
    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint signed rand_coord(int mode);
        case (mode)
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom_range(0, 20 * 65536))) - 10 * 65536;
            default: return longint'($signed($urandom_range(0, 64))) - 32;
        endcase
    endfunction

    task automatic add_cam(vec3_t e, vec3_t a, vec3_t u, bit hold);
        camera_q.push_back(pack_cam(e, a, u));
        hold_q.push_back(hold);
    endtask

    // ---------------------------------------------------------------
    // driver: feeds camera transactions from the queue
    // ---------------------------------------------------------------

    int  tx_gap;
    bit  tx_burst;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap        <= 0;
            tx_burst      <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                matrix_q.push_back(view_matrix(s_axis_tdata));
                sent <= sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if ($urandom_range(0, 199) == 0)
                    tx_burst <= ~tx_burst;
                if (tx_gap > 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (camera_q.size() > 0 &&
                         !(hold_q[0] && (matrix_q.size() > 0 || s_axis_tvalid)))
                begin
                    s_axis_tdata  <= camera_q.pop_front();
                    void'(hold_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= pick_gap(tx_burst);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random back-pressure and field-by-field compare
    // ---------------------------------------------------------------

    int rx_gap;
    bit rx_burst;
    string field_name [12] = '{"side_x", "side_y", "side_z", "true_up_x", "true_up_y",
                               "true_up_z", "back_x", "back_y", "back_z",
                               "shift_x", "shift_y", "shift_z"};

    always @(posedge clk or negedge rst_n)
    begin
        view_out_t want;
        int        bad;
        bad = 0;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
            rx_burst      <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                taken <= taken + 1;
                if (matrix_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, actual %h",
                             $realtime, m_axis_tdata);
                    bad++;
                end
                else
                begin
                    want = matrix_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_axis_tdata[18*i +: 18] !== want[18*i +: 18])
                        begin
                            $display("%0t: %s expected %0d actual %0d", $realtime,
                                     field_name[i], $signed(want[18*i +: 18]),
                                     $signed(m_axis_tdata[18*i +: 18]));
                            bad++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (m_axis_tdata[162+32*i +: 32] !== want[162+32*i +: 32])
                        begin
                            $display("%0t: %s expected %0d actual %0d", $realtime,
                                     field_name[9+i], $signed(want[162+32*i +: 32]),
                                     $signed(m_axis_tdata[162+32*i +: 32]));
                            bad++;
                        end
                    if (m_axis_tdata[263:258] !== 6'd0)
                    begin
                        $display("%0t: pad expected 0 actual %b", $realtime,
                                 m_axis_tdata[263:258]);
                        bad++;
                    end
                end
                if (bad != 0)
                    errors <= errors + bad;
            end
            if ($urandom_range(0, 199) == 0)
                rx_burst <= ~rx_burst;
            if (rx_gap > 0)
            begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap        <= pick_gap(rx_burst);
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     matrix_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial
    begin
        vec3_t e;
        vec3_t a;
        vec3_t u;
        longint signed k;
        int mode;
        errors = 0;
        sent = 0;
        taken = 0;
        degenerate_cnt = 0;
        cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;

        // directed: plain camera looking down -z with y up
        e = '{0, 0, 5 * 65536}; a = '{0, 0, 0}; u = '{0, 65536, 0};
        add_cam(e, a, u, 1'b0);
        // all zero: eye on aim and zero up
        e = '{0, 0, 0}; a = '{0, 0, 0}; u = '{0, 0, 0};
        add_cam(e, a, u, 1'b0);
        // eye equal to aim, nonzero
        e = '{123456, -98765, 7}; a = e; u = '{0, 65536, 0};
        add_cam(e, a, u, 1'b0);
        // up parallel to forward
        e = '{0, 0, 0}; a = '{0, 3 * 65536, 0}; u = '{0, -7 * 65536, 0};
        add_cam(e, a, u, 1'b0);
        // zero up vector
        e = '{65536, 2 * 65536, 3 * 65536}; a = '{-65536, 0, 9}; u = '{0, 0, 0};
        add_cam(e, a, u, 1'b0);
        // extreme coordinates, largest difference
        e = '{-2147483648, -2147483648, -2147483648};
        a = '{2147483647, 2147483647, 2147483647};
        u = '{-2147483648, 2147483647, 0};
        add_cam(e, a, u, 1'b0);
        e = '{2147483647, -2147483648, 2147483647};
        a = '{-2147483648, 2147483647, -2147483648};
        u = '{2147483647, 2147483647, 2147483647};
        add_cam(e, a, u, 1'b0);
        // translation saturation: eye far out along the right and up axes
        e = '{2147483647, 2147483647, 2147483647}; a = '{2147483647, 2147483647, 0};
        u = '{-2147483648, 65536, 0};
        add_cam(e, a, u, 1'b0);
        e = '{-2147483648, -2147483648, -2147483648}; a = '{0, 0, 0};
        u = '{0, 0, 65536};
        add_cam(e, a, u, 1'b0);
        // tiny vectors that need large normalizing shifts
        e = '{0, 0, 0}; a = '{1, 0, 0}; u = '{0, 0, 1};
        add_cam(e, a, u, 1'b0);
        e = '{-1, -1, -1}; a = '{0, 0, 0}; u = '{-1, 1, 0};
        add_cam(e, a, u, 1'b0);
        // axis-aligned and negative axis views, rounding ties
        e = '{0, 0, 0}; a = '{-65536, 0, 0}; u = '{0, 0, -65536};
        add_cam(e, a, u, 1'b0);
        e = '{32768, -32768, 98304}; a = '{-65536, 65536, 65536}; u = '{1, 1, 1};
        add_cam(e, a, u, 1'b0);
        e = '{0, 0, 0}; a = '{65536, 65536, 65536}; u = '{-2147483648, 0, 2147483647};
        add_cam(e, a, u, 1'b0);

        // random: mostly well-formed cameras, some degenerate ones
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
            begin
                e[i] = rand_coord(mode);
                a[i] = rand_coord(mode);
                u[i] = rand_coord($urandom_range(0, 2));
            end
            case ($urandom_range(0, 19))
                0:
                begin
                    a = e;
                    degenerate_cnt++;
                end
                1:
                begin
                    // up along the view direction, scaled
                    k = longint'($urandom_range(0, 8)) - 4;
                    for (int i = 0; i < 3; i++)
                    begin
                        e[i] = rand_coord(1);
                        a[i] = rand_coord(1);
                        u[i] = (a[i] - e[i]) * k;
                    end
                    degenerate_cnt++;
                end
                2:
                begin
                    u = '{0, 0, 0};
                    degenerate_cnt++;
                end
                default: ;
            endcase
            add_cam(e, a, u, (n == RANDOM_ITEMS / 2) || (n == RANDOM_ITEMS / 4));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (camera_q.size() == 0 && !s_axis_tvalid);
        @(posedge clk);
        wait (matrix_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d camera transactions (%0d degenerate), %0d results checked",
                 sent, degenerate_cnt, taken);
        $display("random gaps on both sides, two drain pauses, %0d cycles", cycles);
        if (errors == 0 && matrix_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
